// ----- hdl/cba_pkg.sv -----
package cba_pkg;

  // sizes of the stores
  localparam int MAX_BLOCKS = 1024;
  localparam int MAX_FILES  = 64;

  // field widths
  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int ID_W   = $clog2(MAX_FILES);
  localparam int FCNT_W = $clog2(MAX_FILES + 1);

  // used-bit map organization: one bit per block, packed into words
  localparam int WORD_W  = 16;
  localparam int OFS_W   = $clog2(WORD_W);
  localparam int WORDS   = MAX_BLOCKS / WORD_W;
  localparam int WADDR_W = BLK_W - OFS_W;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_ENTRY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK_EVAL,
    S_MRK_RD,
    S_MRK_WR,
    S_DIR_RD,
    S_DIR_EVAL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [BLK_W-1:0]  start_block;
    logic [CNT_W-1:0]  block_count;
    logic [ID_W-1:0]   entry_index;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   file_id;
    logic [BLK_W-1:0]  first_block;
    logic [BLK_W-1:0]  last_block;
  } out_t;

  // access to the used-bit map
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } map_req_t;

  // access to the file directory
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ID_W-1:0]   addr;
    logic [BLK_W-1:0]  first;
    logic [BLK_W-1:0]  last;
  } dir_req_t;

endpackage

// ----- hdl/cba_map.sv -----
module cba_map (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cba_pkg::map_req_t          req,
  output logic [cba_pkg::WORD_W-1:0] rdata
);
  import cba_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  row_valid_r;
  logic [WORD_W-1:0] rd_q_r;
  logic              rd_vld_r;

  // row valid bits: a row never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (req.wr) begin
      row_valid_r[req.addr] <= 1'b1;
    end
  end

  // map memory, registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.data;
    end
    if (req.rd) begin
      rd_q_r   <= mem[req.addr];
      rd_vld_r <= row_valid_r[req.addr];
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- hdl/cba_dir.sv -----
module cba_dir (
  input  logic                      clk,
  input  cba_pkg::dir_req_t         req,
  output logic [cba_pkg::BLK_W-1:0] rd_first,
  output logic [cba_pkg::BLK_W-1:0] rd_last
);
  import cba_pkg::*;

  logic [2*BLK_W-1:0] mem [MAX_FILES];
  logic [2*BLK_W-1:0] rd_q_r;

  // directory memory holding first and last block of each file
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= {req.first, req.last};
    end
    if (req.rd) begin
      rd_q_r <= mem[req.addr];
    end
  end

  assign rd_first = rd_q_r[2*BLK_W-1:BLK_W];
  assign rd_last  = rd_q_r[BLK_W-1:0];

endmodule

// ----- hdl/contiguous_block_allocator.sv -----
// Contiguous block allocator. One command is taken at a time. An allocate
// command walks the used-bit map (16 blocks per word) over the requested
// range twice: a check pass that reads and tests each map word and a mark
// pass that reads each word and writes it back with the range bits set;
// a rejected range stops at the first word with a used block.
// Full-directory, zero-length and out-of-range requests, and directory
// reads, skip the map walk. The map starts all free with no clearing pass
// after reset. The next command is accepted while a result still waits in
// the output register.
module contiguous_block_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cba_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cba_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [cba_pkg::CNT_W-1:0] cfg_wdata
);
  import cba_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cfg_r;
  logic [FCNT_W-1:0]  file_count_r, file_count_nxt;
  logic [BLK_W-1:0]   start_r, start_nxt;
  logic [BLK_W-1:0]   end_r, end_nxt;
  logic [ID_W-1:0]    idx_r, idx_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  out_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  map_req_t           map_req;
  logic [WORD_W-1:0]  map_rdata;
  dir_req_t           dir_req;
  logic [BLK_W-1:0]   dir_first, dir_last;

  logic               accept;
  logic [CNT_W-1:0]   eff_blocks;
  logic [CNT_W:0]     range_sum;
  logic               range_bad;
  logic               dir_full;
  logic               idx_ok;
  logic [WADDR_W-1:0] start_word, end_word;
  logic [OFS_W-1:0]   lo_bit, hi_bit;
  logic [WORD_W-1:0]  word_mask;
  logic               last_word;
  logic               overlap;

  cba_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata)
  );

  cba_dir u_dir (
    .clk      (clk),
    .req      (dir_req),
    .rd_first (dir_first),
    .rd_last  (dir_last)
  );

  // request checks on the incoming command
  assign accept     = in_valid && in_ready;
  assign eff_blocks = (cfg_r > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_r;
  assign range_sum  = {1'b0, CNT_W'(in_data.start_block)} + {1'b0, in_data.block_count};
  assign range_bad  = (in_data.block_count == '0) || (range_sum > {1'b0, eff_blocks});
  assign dir_full   = (file_count_r == FCNT_W'(MAX_FILES));
  assign idx_ok     = ({1'b0, in_data.entry_index} < file_count_r);

  // mask of the requested blocks inside the current map word
  assign start_word = start_r[BLK_W-1:OFS_W];
  assign end_word   = end_r[BLK_W-1:OFS_W];
  assign lo_bit     = (word_r == start_word) ? start_r[OFS_W-1:0] : '0;
  assign hi_bit     = (word_r == end_word) ? end_r[OFS_W-1:0] : '1;
  assign word_mask  = ({WORD_W{1'b1}} << lo_bit) &
                      ({WORD_W{1'b1}} >> (OFS_W'(WORD_W - 1) - hi_bit));
  assign last_word  = (word_r == end_word);
  assign overlap    = |(map_rdata & word_mask);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_READ) begin
            state_nxt = idx_ok ? S_DIR_RD : S_FIN;
          end else if (dir_full || range_bad) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_CHK_RD;
          end
        end
      end
      S_CHK_RD:   state_nxt = S_CHK_EVAL;
      S_CHK_EVAL: begin
        if (overlap) begin
          state_nxt = S_FIN;
        end else if (last_word) begin
          state_nxt = S_MRK_RD;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_MRK_RD:   state_nxt = S_MRK_WR;
      S_MRK_WR:   state_nxt = last_word ? S_FIN : S_MRK_RD;
      S_DIR_RD:   state_nxt = S_DIR_EVAL;
      S_DIR_EVAL: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory accesses
  always_comb begin
    start_nxt      = start_r;
    end_nxt        = end_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    res_nxt        = res_r;
    file_count_nxt = file_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    map_req        = '0;
    dir_req        = '0;
    map_req.addr   = word_r;
    dir_req.addr   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          start_nxt = in_data.start_block;
          end_nxt   = range_sum[BLK_W-1:0] - BLK_W'(1);
          idx_nxt   = in_data.entry_index;
          word_nxt  = in_data.start_block[BLK_W-1:OFS_W];
          res_nxt   = '0;
          if (in_data.cmd == CMD_READ) begin
            res_nxt.status = ST_NO_ENTRY;
          end else if (dir_full) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.status = ST_REJECT;
          end
        end
      end
      S_CHK_RD: begin
        map_req.rd = 1'b1;
      end
      S_CHK_EVAL: begin
        if (!overlap) begin
          word_nxt = last_word ? start_word : word_r + WADDR_W'(1);
        end
      end
      S_MRK_RD: begin
        map_req.rd = 1'b1;
      end
      S_MRK_WR: begin
        map_req.wr   = 1'b1;
        map_req.data = map_rdata | word_mask;
        if (last_word) begin
          dir_req.wr          = 1'b1;
          dir_req.addr        = file_count_r[ID_W-1:0];
          dir_req.first       = start_r;
          dir_req.last        = end_r;
          res_nxt.status      = ST_OK;
          res_nxt.file_id     = file_count_r[ID_W-1:0];
          res_nxt.first_block = start_r;
          res_nxt.last_block  = end_r;
          file_count_nxt      = file_count_r + FCNT_W'(1);
        end else begin
          word_nxt = word_r + WADDR_W'(1);
        end
      end
      S_DIR_RD: begin
        dir_req.rd = 1'b1;
      end
      S_DIR_EVAL: begin
        res_nxt.status      = ST_OK;
        res_nxt.file_id     = idx_r;
        res_nxt.first_block = dir_first;
        res_nxt.last_block  = dir_last;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      file_count_r <= '0;
      out_valid_r  <= 1'b0;
      cfg_r        <= CNT_W'(MAX_BLOCKS);
    end else begin
      state_r      <= state_nxt;
      file_count_r <= file_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    idx_r      <= idx_nxt;
    word_r     <= word_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // directory count never passes the directory size
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    file_count_r <= FCNT_W'(MAX_FILES))
    else $error("file count beyond directory size");

  // file count only steps up by one, on a completed allocation
  a_fc_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (file_count_r != $past(file_count_r)) |->
      (file_count_r == $past(file_count_r) + FCNT_W'(1)) && $past(state_r) == S_MRK_WR)
    else $error("file count changed unexpectedly");

  // map writes stay inside the requested word range
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    map_req.wr |-> (word_r >= start_word) && (word_r <= end_word))
    else $error("map write outside requested range");

  // a new transfer on the result side comes only from the finish state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside finish state");

endmodule

// ----- tb/sv/contiguous_block_allocator_tb.sv -----
`timescale 1ns / 1ps

module contiguous_block_allocator_tb;
  import cba_pkg::*;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 200;
  localparam int DRAIN_WAIT  = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;

  contiguous_block_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // shadow of the allocator state
  bit               blk_used [MAX_BLOCKS];
  logic [BLK_W-1:0] dir_first [MAX_FILES];
  logic [BLK_W-1:0] dir_last [MAX_FILES];
  int unsigned      n_files = 0;
  logic [CNT_W-1:0] disk_blocks = CNT_W'(MAX_BLOCKS);

  in_t  req_queue[$];
  out_t awaited_results[$];

  int n_queued = 0;
  int n_accepted = 0;
  int results_seen = 0;
  int n_errors = 0;
  int n_cfg = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_cnt = 0;

  // answer to one request, updating the shadow state on a successful allocation
  function automatic out_t alloc_result(in_t req);
    out_t        r;
    int unsigned eff;
    int unsigned lo;
    int unsigned hi;
    bit          clash;
    r = '0;
    r.status = ST_OK;
    eff = (disk_blocks > MAX_BLOCKS) ? MAX_BLOCKS : disk_blocks;
    lo = req.start_block;
    if (req.cmd == CMD_READ) begin
      if (req.entry_index < n_files) begin
        r.file_id     = req.entry_index;
        r.first_block = dir_first[req.entry_index];
        r.last_block  = dir_last[req.entry_index];
      end else begin
        r.status = ST_NO_ENTRY;
      end
    end else if (n_files >= MAX_FILES) begin
      r.status = ST_FULL;
    end else if (req.block_count == 0 || lo + req.block_count > eff) begin
      r.status = ST_REJECT;
    end else begin
      hi = lo + req.block_count - 1;
      clash = 1'b0;
      for (int b = lo; b <= hi; b++) begin
        if (blk_used[b]) clash = 1'b1;
      end
      if (clash) begin
        r.status = ST_REJECT;
      end else begin
        for (int b = lo; b <= hi; b++) blk_used[b] = 1'b1;
        dir_first[n_files] = BLK_W'(lo);
        dir_last[n_files]  = BLK_W'(hi);
        r.file_id     = ID_W'(n_files);
        r.first_block = BLK_W'(lo);
        r.last_block  = BLK_W'(hi);
        n_files++;
      end
    end
    return r;
  endfunction

  // sender: bursts of transfers with random gaps
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   <= 0;
      burst_left <= 8;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(alloc_result(in_data));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && req_queue.size() > 0) begin
          in_data  <= req_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left <= $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int  stall_tick = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_tick <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      stall_tick <= (stall_tick == 179) ? 0 : stall_tick + 1;
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_tick < 50) begin
        out_ready <= 1'b1;
      end else if (stall_tick < 120) begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end else begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_seen[out_data.status]++;
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: status %0d id %0d first %0d last %0d",
               out_data.status, out_data.file_id, out_data.first_block,
               out_data.last_block);
        n_errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          n_errors++;
        end
        if (out_data.file_id !== want.file_id) begin
          $error("file_id: expected %0d, got %0d", want.file_id, out_data.file_id);
          n_errors++;
        end
        if (out_data.first_block !== want.first_block) begin
          $error("first_block: expected %0d, got %0d", want.first_block,
                 out_data.first_block);
          n_errors++;
        end
        if (out_data.last_block !== want.last_block) begin
          $error("last_block: expected %0d, got %0d", want.last_block,
                 out_data.last_block);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_t make_req(logic cmd, int start, int count, int idx);
    in_t r;
    r.cmd         = cmd;
    r.start_block = BLK_W'(start);
    r.block_count = CNT_W'(count);
    r.entry_index = ID_W'(idx);
    return r;
  endfunction

  // random request, mostly small ranges inside the configured disk
  function automatic in_t random_req();
    in_t r;
    int  lim;
    int  pick;
    lim = (disk_blocks > MAX_BLOCKS) ? MAX_BLOCKS : disk_blocks;
    if (lim == 0) lim = 1;
    r.start_block = BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
    r.block_count = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
    r.entry_index = ID_W'($urandom_range(0, MAX_FILES - 1));
    if ($urandom_range(0, 99) < 35) begin
      r.cmd = CMD_READ;
    end else begin
      r.cmd = CMD_ALLOC;
      pick = $urandom_range(0, 19);
      if (pick == 0) r.block_count = '0;
      else if (pick == 2) r.block_count = CNT_W'($urandom_range(1, MAX_BLOCKS));
      else if (pick > 2) r.block_count = CNT_W'($urandom_range(1, 12));
      if ($urandom_range(0, 7) != 0) r.start_block = BLK_W'($urandom_range(0, lim - 1));
    end
    return r;
  endfunction

  task automatic queue_req(in_t r);
    req_queue.push_back(r);
    n_queued++;
  endtask

  // sender pause until every expected result has come back
  task automatic wait_all_answered();
    do @(negedge clk);
    while (n_accepted != n_queued || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_disk_blocks(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    disk_blocks = v;
    n_cfg++;
  endtask

  int phase_blocks [7] = '{0, 40, 1, 300, 2047, 700, 1024};
  int phase_items [7]  = '{40, 150, 40, 180, 160, 140, 140};

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: edges of the fields and the special cases
    queue_req(make_req(CMD_ALLOC, 0, 0, 0));       // zero length
    queue_req(make_req(CMD_READ, 0, 0, 0));        // empty directory
    queue_req(make_req(CMD_ALLOC, 1000, 24, 63));  // range ending on the last block
    queue_req(make_req(CMD_ALLOC, 1023, 1, 0));    // single occupied block
    queue_req(make_req(CMD_ALLOC, 990, 11, 0));    // only the last block clashes
    queue_req(make_req(CMD_ALLOC, 990, 10, 0));
    queue_req(make_req(CMD_ALLOC, 1023, 2, 0));    // past the end
    queue_req(make_req(CMD_ALLOC, 0, 1024, 0));    // whole disk, partly taken
    queue_req(make_req(CMD_ALLOC, 1, 2047, 0));    // widest count
    queue_req(make_req(CMD_ALLOC, 0, 1, 0));
    queue_req(make_req(CMD_ALLOC, 512, 512, 0));
    queue_req(make_req(CMD_ALLOC, 100, 400, 0));   // long range
    queue_req(make_req(CMD_READ, 1023, 2047, 0));
    queue_req(make_req(CMD_READ, 0, 0, 1));
    queue_req(make_req(CMD_READ, 0, 0, 3));
    queue_req(make_req(CMD_READ, 0, 0, 4));        // missing entry
    queue_req(make_req(CMD_READ, 0, 0, 63));
    queue_req(make_req(CMD_ALLOC, 500, 1, 0));
    queue_req(make_req(CMD_ALLOC, 499, 1, 0));     // touches end of an earlier file
    wait_all_answered();

    // random phases, one disk size each
    for (int p = 0; p < 7; p++) begin
      set_disk_blocks(CNT_W'(phase_blocks[p]));
      for (int i = 0; i < phase_items[p]; i++) queue_req(random_req());
      wait_all_answered();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      n_errors += awaited_results.size();
    end

    $display("covered %0d requests over %0d disk sizes, %0d files allocated",
             n_accepted, n_cfg + 1, n_files);
    $display("results: %0d ok, %0d rejected, %0d directory full, %0d missing entry",
             status_seen[ST_OK], status_seen[ST_REJECT], status_seen[ST_FULL],
             status_seen[ST_NO_ENTRY]);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
